// ----- rtl/owvm_pkg.sv -----
// owvm_pkg: shared widths, register codes, force word type and helper functions
// for the omni wheel velocity mixer; no dependencies
// holds the quarter-wave sine table, built at elaboration
package owvm_pkg;

  // field widths
  localparam int SPEED_BITS     = 12;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int ANGLE_BITS     = 10;
  localparam int COEF_W         = 16;
  localparam int VEL_W          = 23;
  localparam int CFG_ADDR_W     = 2;

  // derived widths
  localparam int FORCE_W = SPEED_BITS + 1;
  localparam int TAB_W   = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
  localparam int MUL_W   = SPEED_BITS + TRIG_W;
  localparam int PROD_W  = COEF_W + 1 + FORCE_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int HALF_W  = ANGLE_BITS - 1;

  // angle constants
  localparam logic [HALF_W-1:0]     DEG_90     = HALF_W'(90);
  localparam logic [HALF_W-1:0]     DEG_180    = HALF_W'(180);
  localparam logic [HALF_W-1:0]     DEG_270    = HALF_W'(270);
  localparam logic [ANGLE_BITS-1:0] DEG_360    = ANGLE_BITS'(360);
  localparam int                    TAB_LAST   = 90;
  localparam int                    TAB_IDX_W  = 7;

  // output saturation
  localparam logic signed [SUM_W-1:0] VEL_LIMIT = SUM_W'(2621440);

  // queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SIDE_X = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_SIDE_Y = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_REAR_Y = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_ROT    = CFG_ADDR_W'(3);

  // register reset values
  localparam logic [COEF_W-1:0] SIDE_X_RST = COEF_W'(3736);
  localparam logic [COEF_W-1:0] SIDE_Y_RST = COEF_W'(2163);
  localparam logic [COEF_W-1:0] REAR_Y_RST = COEF_W'(4260);
  localparam logic [COEF_W-1:0] ROT_RST    = COEF_W'(9241);

  // force word passed from the front end to the back end
  typedef struct packed {
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
    logic signed [FORCE_W-1:0] fw;
    logic                      stop;
  } force_word_t;

  typedef logic [TAB_W-1:0] sine_tab_t [0:TAB_LAST];

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // sin(k deg) in Q30 by a Taylor series, integer only
  function automatic logic [63:0] sin_q30(input int unsigned k);
    logic [63:0] xq;
    logic [63:0] term;
    logic [63:0] sum;
    xq   = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    term = xq;
    sum  = xq;
    for (int unsigned n = 1; n <= 10; n++) begin
      term = (term * xq) >> 30;
      term = (term * xq) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n[0]) sum = sum - term;
      else      sum = sum + term;
    end
    return sum;
  endfunction

  // quarter-wave table rounded half up to the trig fraction width
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] s;
    for (int unsigned k = 0; k <= TAB_LAST; k++) begin
      s = sin_q30(k);
      s = (s + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      tab[k] = s[TAB_W-1:0];
    end
    tab[0]        = '0;
    tab[TAB_LAST] = TAB_W'(64'd1 << TRIG_FRAC_BITS);
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // signed sine of a whole-degree angle in 0..359 by quadrant symmetry
  function automatic logic signed [TRIG_W-1:0] sin_lookup(input logic [HALF_W-1:0] a);
    logic [HALF_W-1:0]    r;
    logic [HALF_W-1:0]    idx;
    logic                 neg;
    logic                 mir;
    logic [TRIG_W-1:0]    mag;
    if (a >= DEG_270) begin
      r = a - DEG_270; neg = 1'b1; mir = 1'b1;
    end else if (a >= DEG_180) begin
      r = a - DEG_180; neg = 1'b1; mir = 1'b0;
    end else if (a >= DEG_90) begin
      r = a - DEG_90;  neg = 1'b0; mir = 1'b1;
    end else begin
      r = a;           neg = 1'b0; mir = 1'b0;
    end
    idx = mir ? (DEG_90 - r) : r;
    mag = TRIG_W'(SINE_TAB[idx[TAB_IDX_W-1:0]]);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // speed times trig value, scaled down with truncation toward zero
  function automatic logic signed [FORCE_W-1:0] scale_trunc(
    input logic signed [MUL_W-1:0] p
  );
    logic signed [MUL_W-1:0] adj;
    logic signed [MUL_W-1:0] shf;
    adj = p[MUL_W-1] ? (p + MUL_W'((64'd1 << TRIG_FRAC_BITS) - 64'd1)) : p;
    shf = adj >>> TRIG_FRAC_BITS;
    return shf[FORCE_W-1:0];
  endfunction

  // clamp a wheel sum to the velocity limit
  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > VEL_LIMIT)       c = VEL_LIMIT;
    else if (v < -VEL_LIMIT) c = -VEL_LIMIT;
    else                     c = v;
    return c[VEL_W-1:0];
  endfunction

endpackage

// ----- rtl/owvm_front.sv -----
// owvm_front: command decode and polar-to-force conversion, two register stages
// depends on owvm_pkg (sine table, truncating scale)
module owvm_front import owvm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic                         in_func,
  input  logic signed [ANGLE_BITS-1:0] in_angle,
  input  logic signed [SPEED_BITS-1:0] in_speed,
  input  logic signed [SPEED_BITS-1:0] in_rot_speed,
  input  logic signed [SPEED_BITS-1:0] in_cart_x,
  input  logic signed [SPEED_BITS-1:0] in_cart_y,
  output logic                         push_vld,
  output force_word_t                  push_word
);

  // stage one registers
  logic                         f1_vld_r;
  logic                         f1_trig_r, f1_trig_nxt;
  logic signed [SPEED_BITS-1:0] f1_spd_r;
  logic signed [TRIG_W-1:0]     f1_cos_r, f1_cos_nxt;
  logic signed [TRIG_W-1:0]     f1_sin_r, f1_sin_nxt;
  logic signed [FORCE_W-1:0]    f1_fx_r, f1_fx_nxt;
  logic signed [FORCE_W-1:0]    f1_fy_r, f1_fy_nxt;
  logic signed [FORCE_W-1:0]    f1_fw_r, f1_fw_nxt;
  logic                         f1_stop_r, f1_stop_nxt;

  // stage two registers
  logic                         f2_vld_r;
  force_word_t                  f2_word_r, f2_word_nxt;

  logic                         ang_neg;
  logic                         spin;
  logic [HALF_W-1:0]            ang_u;
  logic [ANGLE_BITS-1:0]        cos_sum;
  logic [ANGLE_BITS-1:0]        cos_wrap;
  logic signed [FORCE_W-1:0]    spd_ext;
  logic signed [FORCE_W-1:0]    rot_ext;
  logic signed [FORCE_W-1:0]    cx_ext;
  logic signed [FORCE_W-1:0]    cy_ext;
  logic signed [MUL_W-1:0]      p_cos;
  logic signed [MUL_W-1:0]      p_sin;

  // classify the command and look up the trig values
  always_comb begin
    ang_neg  = in_angle[ANGLE_BITS-1];
    ang_u    = in_angle[HALF_W-1:0];
    spin     = ang_neg || ({1'b0, ang_u} >= DEG_360);
    cos_sum  = {1'b0, ang_u} + {1'b0, DEG_90};
    cos_wrap = (cos_sum >= DEG_360) ? (cos_sum - DEG_360) : cos_sum;
    spd_ext  = FORCE_W'(in_speed);
    rot_ext  = FORCE_W'(in_rot_speed);
    cx_ext   = FORCE_W'(in_cart_x);
    cy_ext   = FORCE_W'(in_cart_y);

    f1_cos_nxt  = sin_lookup(cos_wrap[HALF_W-1:0]);
    f1_sin_nxt  = sin_lookup(ang_u);
    f1_trig_nxt = 1'b0;
    f1_fx_nxt   = '0;
    f1_fy_nxt   = '0;
    f1_fw_nxt   = rot_ext;
    f1_stop_nxt = 1'b0;
    if (in_func) begin
      f1_fx_nxt   = cx_ext;
      f1_fy_nxt   = cy_ext;
      f1_stop_nxt = (in_cart_x == '0) && (in_cart_y == '0) && (in_rot_speed == '0);
    end else if (spin) begin
      f1_fw_nxt = ang_neg ? -spd_ext : spd_ext;
    end else begin
      f1_trig_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= in_vld;
    end
    f1_trig_r <= f1_trig_nxt;
    f1_spd_r  <= in_speed;
    f1_cos_r  <= f1_cos_nxt;
    f1_sin_r  <= f1_sin_nxt;
    f1_fx_r   <= f1_fx_nxt;
    f1_fy_r   <= f1_fy_nxt;
    f1_fw_r   <= f1_fw_nxt;
    f1_stop_r <= f1_stop_nxt;
  end

  // scale speed by cos and sin, truncate toward zero
  assign p_cos = MUL_W'(f1_spd_r) * MUL_W'(f1_cos_r);
  assign p_sin = MUL_W'(f1_spd_r) * MUL_W'(f1_sin_r);

  always_comb begin
    f2_word_nxt.fx   = f1_trig_r ? scale_trunc(p_cos) : f1_fx_r;
    f2_word_nxt.fy   = f1_trig_r ? scale_trunc(p_sin) : f1_fy_r;
    f2_word_nxt.fw   = f1_fw_r;
    f2_word_nxt.stop = f1_stop_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else begin
      f2_vld_r <= f1_vld_r;
    end
    f2_word_r <= f2_word_nxt;
  end

  assign push_vld  = f2_vld_r;
  assign push_word = f2_word_r;

endmodule

// ----- rtl/owvm_queue.sv -----
// owvm_queue: short register queue of force words between front and back end
// depends on owvm_pkg (force_word_t, queue depth)
module owvm_queue import owvm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_vld,
  input  force_word_t push_word,
  input  logic        pop,
  output logic        not_empty,
  output logic        full,
  output force_word_t head_word
);

  force_word_t              q_r [0:QUEUE_DEPTH-1];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                     do_push;
  logic                     do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_word = q_r[rd_ptr_r];
  assign do_push   = push_vld && !full;
  assign do_pop    = pop && not_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ----- rtl/owvm_back.sv -----
// owvm_back: coefficient registers, weighted products and saturated wheel sums
// depends on owvm_pkg (register codes, widths, saturation)
module owvm_back import owvm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COEF_W-1:0]     cfg_wdata,
  input  logic                  word_vld,
  input  force_word_t           word,
  output logic                  out_valid,
  output logic [VEL_W-1:0]      out_wheel_a_vel,
  output logic [VEL_W-1:0]      out_wheel_b_vel,
  output logic [VEL_W-1:0]      out_wheel_c_vel,
  output logic                  out_stop_now
);

  logic [COEF_W-1:0]        side_x_r, side_y_r, rear_y_r, rot_r;

  logic                     b1_vld_r;
  logic signed [PROD_W-1:0] p_sx_r, p_sy_r, p_ry_r, p_rot_r;
  logic                     b1_stop_r;

  logic signed [SUM_W-1:0]  sum_a, sum_b, sum_c;

  logic                     out_valid_r;
  logic [VEL_W-1:0]         vel_a_r, vel_b_r, vel_c_r;
  logic                     stop_r;

  // coefficient register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_x_r <= SIDE_X_RST;
      side_y_r <= SIDE_Y_RST;
      rear_y_r <= REAR_Y_RST;
      rot_r    <= ROT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SIDE_X: side_x_r <= cfg_wdata;
        REG_SIDE_Y: side_y_r <= cfg_wdata;
        REG_REAR_Y: rear_y_r <= cfg_wdata;
        REG_ROT:    rot_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // weighted products, one multiplier each
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
    end else begin
      b1_vld_r <= word_vld;
    end
    p_sx_r    <= PROD_W'($signed({1'b0, side_x_r})) * PROD_W'(word.fx);
    p_sy_r    <= PROD_W'($signed({1'b0, side_y_r})) * PROD_W'(word.fy);
    p_ry_r    <= PROD_W'($signed({1'b0, rear_y_r})) * PROD_W'(word.fy);
    p_rot_r   <= PROD_W'($signed({1'b0, rot_r})) * PROD_W'(word.fw);
    b1_stop_r <= word.stop;
  end

  // wheel sums
  always_comb begin
    sum_a = SUM_W'(p_sx_r) + SUM_W'(p_sy_r) + SUM_W'(p_rot_r);
    sum_b = SUM_W'(p_rot_r) - SUM_W'(p_ry_r);
    sum_c = SUM_W'(p_sy_r) - SUM_W'(p_sx_r) + SUM_W'(p_rot_r);
  end

  // saturated output registers, strobe for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= b1_vld_r;
    end
    vel_a_r <= sat_vel(sum_a);
    vel_b_r <= sat_vel(sum_b);
    vel_c_r <= sat_vel(sum_c);
    stop_r  <= b1_stop_r;
  end

  assign out_valid       = out_valid_r;
  assign out_wheel_a_vel = vel_a_r;
  assign out_wheel_b_vel = vel_b_r;
  assign out_wheel_c_vel = vel_c_r;
  assign out_stop_now    = stop_r;

endmodule

// ----- rtl/omni_wheel_velocity_mixer.sv -----
// omni_wheel_velocity_mixer: three-wheel omni drive velocity mixer, top level
// an accepted start passes front stages f1, f2, the queue and back stage b1 to out_valid
// throughput: one word per cycle; the back end drains the queue every cycle, so busy stays low
// reset: synchronous, clears pipeline valids and the queue, loads default coefficients
// depends on owvm_pkg, owvm_front, owvm_queue, owvm_back
module omni_wheel_velocity_mixer import owvm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_func,
  input  logic signed [ANGLE_BITS-1:0] in_angle,
  input  logic signed [SPEED_BITS-1:0] in_speed,
  input  logic signed [SPEED_BITS-1:0] in_rot_speed,
  input  logic signed [SPEED_BITS-1:0] in_cart_x,
  input  logic signed [SPEED_BITS-1:0] in_cart_y,
  output logic                         out_valid,
  output logic signed [VEL_W-1:0]      out_wheel_a_vel,
  output logic signed [VEL_W-1:0]      out_wheel_b_vel,
  output logic signed [VEL_W-1:0]      out_wheel_c_vel,
  output logic                         out_stop_now,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [COEF_W-1:0]            cfg_wdata
);

  logic        accept;
  logic        push_vld;
  force_word_t push_word;
  logic        q_not_empty;
  logic        q_full;
  force_word_t head_word;

  assign accept = start && !busy;
  assign busy   = q_full;

  // front end: decode and trig
  owvm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (accept),
    .in_func      (in_func),
    .in_angle     (in_angle),
    .in_speed     (in_speed),
    .in_rot_speed (in_rot_speed),
    .in_cart_x    (in_cart_x),
    .in_cart_y    (in_cart_y),
    .push_vld     (push_vld),
    .push_word    (push_word)
  );

  // queue between the two halves
  owvm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_word (push_word),
    .pop       (q_not_empty),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head_word (head_word)
  );

  // back end: weighting and saturation
  owvm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .word_vld        (q_not_empty),
    .word            (head_word),
    .out_valid       (out_valid),
    .out_wheel_a_vel (out_wheel_a_vel),
    .out_wheel_b_vel (out_wheel_b_vel),
    .out_wheel_c_vel (out_wheel_c_vel),
    .out_stop_now    (out_stop_now)
  );

endmodule

// ----- rtl/owvm_checker.sv -----
// owvm_checker: port-level assertions for omni_wheel_velocity_mixer, bound to the top
// depends on owvm_pkg and omni_wheel_velocity_mixer
module owvm_checker import owvm_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic signed [VEL_W-1:0]      out_wheel_a_vel,
  input logic signed [VEL_W-1:0]      out_wheel_b_vel,
  input logic signed [VEL_W-1:0]      out_wheel_c_vel,
  input logic                         out_stop_now
);

  localparam logic signed [VEL_W-1:0] LIM = VEL_W'(2621440);

  // the back end never lets the queue fill
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every accepted word yields a strobe once through the front, queue and back stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result strobe missing");

  // no strobe without an earlier accepted word
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##5 !out_valid)
    else $error("unexpected result strobe");

  // abrupt stop comes with zero wheel velocities
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stop_now) |->
      (out_wheel_a_vel == '0) && (out_wheel_b_vel == '0) && (out_wheel_c_vel == '0))
    else $error("stop with nonzero wheel velocity");

  // velocities stay inside the saturation limit
  a_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_wheel_a_vel <= LIM) && (out_wheel_a_vel >= -LIM) &&
      (out_wheel_b_vel <= LIM) && (out_wheel_b_vel >= -LIM) &&
      (out_wheel_c_vel <= LIM) && (out_wheel_c_vel >= -LIM))
    else $error("wheel velocity out of limit");

endmodule

bind omni_wheel_velocity_mixer owvm_checker u_owvm_checker (.*);

// ----- sim/tb_omni_wheel_velocity_mixer.sv -----
// tb_omni_wheel_velocity_mixer: self-checking testbench for the omni wheel velocity mixer
// drives a directed command table then bursty random commands under several coefficient sets
// depends on owvm_pkg and omni_wheel_velocity_mixer
module tb_omni_wheel_velocity_mixer import owvm_pkg::*;;

  // command codes
  localparam logic FN_POLAR = 1'b0;
  localparam logic FN_CART  = 1'b1;

  localparam int PIPE_LAT        = 5;
  localparam int DRAIN_PAD       = PIPE_LAT + 4;
  localparam int STALL_LIMIT     = 2000;
  localparam int RESET_CYCLES    = 6;
  localparam int ITEMS_PER_PHASE = 113;
  localparam int NUM_PHASES      = 6;
  localparam int NUM_DIRECTED    = 23;

  localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
  localparam longint          VEL_CLIP      = 2621440;

  typedef struct packed {
    logic                         func;
    logic signed [ANGLE_BITS-1:0] angle;
    logic signed [SPEED_BITS-1:0] speed;
    logic signed [SPEED_BITS-1:0] rot;
    logic signed [SPEED_BITS-1:0] cart_x;
    logic signed [SPEED_BITS-1:0] cart_y;
  } cmd_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] a;
    logic signed [VEL_W-1:0] b;
    logic signed [VEL_W-1:0] c;
    logic                    stop;
  } wheel_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   pin;
    wheel_t want;
  } dir_row_t;

  // directed commands; rows with pin set carry wheel values read straight off the spec
  dir_row_t dir_tab [0:NUM_DIRECTED-1] = '{
    '{'{FN_CART, -512, 2047, 0, 0, 0},         1'b1, '{0, 0, 0, 1'b1}},
    '{'{FN_CART, 511, -2048, 0, 1, 0},         1'b1, '{3736, 0, -3736, 1'b0}},
    '{'{FN_CART, 0, 0, 1, 0, 0},               1'b1, '{9241, 9241, 9241, 1'b0}},
    '{'{FN_CART, 0, 0, 0, 0, 1},               1'b1, '{2163, -4260, 2163, 1'b0}},
    '{'{FN_POLAR, -1, 100, 5, 0, 0},           1'b1, '{-924100, -924100, -924100, 1'b0}},
    '{'{FN_POLAR, 360, 100, -7, 0, 0},         1'b1, '{924100, 924100, 924100, 1'b0}},
    '{'{FN_POLAR, 0, 2047, 0, 0, 0},           1'b1, '{2621440, 0, -2621440, 1'b0}},
    '{'{FN_POLAR, 90, 100, 0, 0, 0},           1'b1, '{216300, -426000, 216300, 1'b0}},
    '{'{FN_CART, 0, 0, 2047, 2047, 2047},      1'b1, '{2621440, 2621440, 2621440, 1'b0}},
    '{'{FN_CART, 0, 0, -2048, -2048, -2048},   1'b1, '{-2621440, -2621440, -2621440, 1'b0}},
    '{'{FN_POLAR, -512, -2048, 2047, 0, 0},    1'b1, '{2621440, 2621440, 2621440, 1'b0}},
    '{'{FN_POLAR, 511, -2048, 0, 0, 0},        1'b1, '{-2621440, -2621440, -2621440, 1'b0}},
    '{'{FN_POLAR, 0, 0, 0, 0, 0},              1'b1, '{0, 0, 0, 1'b0}},
    '{'{FN_CART, 0, 0, -1, 0, 0},              1'b1, '{-9241, -9241, -9241, 1'b0}},
    '{'{FN_POLAR, 359, -2048, -2048, 0, 0},    1'b0, '0},
    '{'{FN_POLAR, 45, 1000, 0, -2048, 2047},   1'b0, '0},
    '{'{FN_POLAR, 135, -777, 300, 0, 0},       1'b0, '0},
    '{'{FN_POLAR, 180, 2047, -2048, 0, 0},     1'b0, '0},
    '{'{FN_POLAR, 225, 1500, 100, 0, 0},       1'b0, '0},
    '{'{FN_POLAR, 270, -2048, 0, 0, 0},        1'b0, '0},
    '{'{FN_POLAR, 315, 333, -1, 0, 0},         1'b0, '0},
    '{'{FN_POLAR, 30, 1, 0, 0, 0},             1'b0, '0},
    '{'{FN_POLAR, 210, -1, 0, 0, 0},           1'b0, '0}
  };

  logic                         clk          = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         start        = 1'b0;
  logic                         busy;
  logic                         in_func      = FN_POLAR;
  logic signed [ANGLE_BITS-1:0] in_angle     = '0;
  logic signed [SPEED_BITS-1:0] in_speed     = '0;
  logic signed [SPEED_BITS-1:0] in_rot_speed = '0;
  logic signed [SPEED_BITS-1:0] in_cart_x    = '0;
  logic signed [SPEED_BITS-1:0] in_cart_y    = '0;
  logic                         out_valid;
  logic signed [VEL_W-1:0]      out_wheel_a_vel;
  logic signed [VEL_W-1:0]      out_wheel_b_vel;
  logic signed [VEL_W-1:0]      out_wheel_c_vel;
  logic                         out_stop_now;
  logic                         cfg_we       = 1'b0;
  logic [CFG_ADDR_W-1:0]        cfg_addr     = REG_SIDE_X;
  logic [COEF_W-1:0]            cfg_wdata    = '0;

  // pinned wheel values travel alongside the command word
  logic   pin_on   = 1'b0;
  wheel_t pin_want = '0;

  // testbench copy of the coefficient registers
  logic [COEF_W-1:0] k_side_x = SIDE_X_RST;
  logic [COEF_W-1:0] k_side_y = SIDE_Y_RST;
  logic [COEF_W-1:0] k_rear_y = REAR_Y_RST;
  logic [COEF_W-1:0] k_rot    = ROT_RST;

  longint sine_q15 [0:90];
  wheel_t wheel_q [$];
  wheel_t want_w;
  cmd_t   seen_cmd;
  int     n_err       = 0;
  int     n_accepted  = 0;
  int     n_results   = 0;
  int     n_settings  = 1;
  int     idle_cycles = 0;
  int     burst_left  = 1;

  omni_wheel_velocity_mixer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_angle        (in_angle),
    .in_speed        (in_speed),
    .in_rot_speed    (in_rot_speed),
    .in_cart_x       (in_cart_x),
    .in_cart_y       (in_cart_y),
    .out_valid       (out_valid),
    .out_wheel_a_vel (out_wheel_a_vel),
    .out_wheel_b_vel (out_wheel_b_vel),
    .out_wheel_c_vel (out_wheel_c_vel),
    .out_stop_now    (out_stop_now),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sin(k deg) in Q30 from an integer odd-power series
  function automatic longint unsigned series_sine_q30(input int unsigned k);
    longint unsigned x;
    longint unsigned t;
    longint unsigned acc;
    x   = (64'(k) * HALF_TURN_Q30 + 64'd90) / 64'd180;
    t   = x;
    acc = x;
    for (int unsigned n = 1; n <= 10; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n[0]) acc = acc - t;
      else      acc = acc + t;
    end
    return acc;
  endfunction

  // signed sine of a heading in 0..359 by quadrant symmetry
  function automatic longint sine_at(input int a);
    int q;
    int r;
    q = a / 90;
    r = a % 90;
    case (q)
      0:       return sine_q15[r];
      1:       return sine_q15[90 - r];
      2:       return -sine_q15[r];
      default: return -sine_q15[90 - r];
    endcase
  endfunction

  function automatic logic signed [VEL_W-1:0] clip_vel(input longint v);
    if (v > VEL_CLIP)  v = VEL_CLIP;
    if (v < -VEL_CLIP) v = -VEL_CLIP;
    return v[VEL_W-1:0];
  endfunction

  // expected wheel velocities for one command under the current coefficients
  function automatic wheel_t mix_wheels(input cmd_t c);
    longint fx;
    longint fy;
    longint fw;
    longint ang;
    longint spd;
    wheel_t w;
    w.stop = 1'b0;
    if (c.func == FN_CART) begin
      fx = longint'($signed(c.cart_x));
      fy = longint'($signed(c.cart_y));
      fw = longint'($signed(c.rot));
      w.stop = (fx == 0 && fy == 0 && fw == 0);
    end else begin
      ang = longint'($signed(c.angle));
      spd = longint'($signed(c.speed));
      if (ang < 0 || ang >= 360) begin
        // spin in place, rotation rate taken from the speed
        fx = 0;
        fy = 0;
        fw = (ang < 0) ? -spd : spd;
      end else begin
        fx = (spd * sine_at(int'((ang + 90) % 360))) / (64'sd1 <<< TRIG_FRAC_BITS);
        fy = (spd * sine_at(int'(ang))) / (64'sd1 <<< TRIG_FRAC_BITS);
        fw = longint'($signed(c.rot));
      end
    end
    w.a = clip_vel(longint'(k_side_x) * fx + longint'(k_side_y) * fy + longint'(k_rot) * fw);
    w.b = clip_vel(-longint'(k_rear_y) * fy + longint'(k_rot) * fw);
    w.c = clip_vel(-longint'(k_side_x) * fx + longint'(k_side_y) * fy + longint'(k_rot) * fw);
    return w;
  endfunction

  task automatic cmp_field(input string nm, input int want, input int got);
    if (want != got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
    end
  endtask

  // result checking and acceptance tracking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        n_results++;
        if (wheel_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result word, expected none, actual a=%0d b=%0d c=%0d stop=%0b",
                   $time, out_wheel_a_vel, out_wheel_b_vel, out_wheel_c_vel, out_stop_now);
        end else begin
          want_w = wheel_q.pop_front();
          cmp_field("wheel_a_vel", want_w.a, out_wheel_a_vel);
          cmp_field("wheel_b_vel", want_w.b, out_wheel_b_vel);
          cmp_field("wheel_c_vel", want_w.c, out_wheel_c_vel);
          cmp_field("stop_now", want_w.stop, out_stop_now);
        end
      end
      if (start && !busy) begin
        n_accepted++;
        seen_cmd = '{in_func, in_angle, in_speed, in_rot_speed, in_cart_x, in_cart_y};
        wheel_q.push_back(pin_on ? pin_want : mix_wheels(seen_cmd));
      end
      idle_cycles = (out_valid || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on cycles without progress
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // present one command and hold it until taken
  task automatic send_cmd(input cmd_t c, input logic pin, input wheel_t pv);
    start        <= 1'b1;
    in_func      <= c.func;
    in_angle     <= c.angle;
    in_speed     <= c.speed;
    in_rot_speed <= c.rot;
    in_cart_x    <= c.cart_x;
    in_cart_y    <= c.cart_y;
    pin_on       <= pin;
    pin_want     <= pv;
    @(posedge clk iff !busy);
  endtask

  // bursts of back-to-back words, random gaps with junk on the idle bus
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      start        <= 1'b0;
      in_func      <= 1'($urandom);
      in_angle     <= ANGLE_BITS'($urandom);
      in_speed     <= SPEED_BITS'($urandom);
      in_rot_speed <= SPEED_BITS'($urandom);
      in_cart_x    <= SPEED_BITS'($urandom);
      in_cart_y    <= SPEED_BITS'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
  endtask

  // stop sending and let the pipeline empty
  task automatic settle();
    start <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_ADDR_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_SIDE_X: k_side_x = val;
      REG_SIDE_Y: k_side_y = val;
      REG_REAR_Y: k_rear_y = val;
      default:    k_rot    = val;
    endcase
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] sx, input logic [COEF_W-1:0] sy,
                            input logic [COEF_W-1:0] ry, input logic [COEF_W-1:0] rot);
    write_coef(REG_SIDE_X, sx);
    write_coef(REG_SIDE_Y, sy);
    write_coef(REG_REAR_Y, ry);
    write_coef(REG_ROT, rot);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // speed-like value: extremes, zero, small, or full range
  function automatic logic signed [SPEED_BITS-1:0] rand_level();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(SPEED_BITS-1){1'b0}}};
      1:       return {1'b0, {(SPEED_BITS-1){1'b1}}};
      2:       return '0;
      3, 4:    return SPEED_BITS'($urandom_range(0, 64) - 32);
      default: return SPEED_BITS'($urandom);
    endcase
  endfunction

  // heading: mostly in range, some spin headings, some near quadrant edges
  function automatic logic signed [ANGLE_BITS-1:0] rand_heading();
    case ($urandom_range(0, 9))
      0:       return ANGLE_BITS'(0 - $urandom_range(1, 512));
      1:       return ANGLE_BITS'($urandom_range(360, 511));
      2:       return ANGLE_BITS'((90 * $urandom_range(0, 3) + 359 + $urandom_range(0, 2)) % 360);
      default: return ANGLE_BITS'($urandom_range(0, 359));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.func   = 1'($urandom);
    c.angle  = rand_heading();
    c.speed  = rand_level();
    c.rot    = rand_level();
    c.cart_x = rand_level();
    c.cart_y = rand_level();
    // cartesian stop and near-stop words
    case ($urandom_range(0, 11))
      0: begin
        c.cart_x = '0;
        c.cart_y = '0;
        c.rot    = '0;
      end
      1: begin
        c.cart_x = '0;
        c.cart_y = '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  // stimulus
  initial begin : stimulus
    for (int k = 0; k <= 90; k++) begin
      sine_q15[k] = longint'((series_sine_q30(k) + (64'd1 << (29 - TRIG_FRAC_BITS)))
                             >> (30 - TRIG_FRAC_BITS));
    end
    sine_q15[0]  = 0;
    sine_q15[90] = 64'sd1 <<< TRIG_FRAC_BITS;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under reset coefficients
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_cmd(dir_tab[i].cmd, dir_tab[i].pin, dir_tab[i].want);
      pace();
    end

    // random words under several coefficient sets
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;
        1: begin
          settle();
          load_coefs('1, '1, '1, '1);
        end
        2: begin
          settle();
          load_coefs('0, '0, '0, '0);
        end
        3: begin
          settle();
          load_coefs('1, '0, '1, '0);
        end
        default: begin
          settle();
          load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                     COEF_W'($urandom));
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        send_cmd(rand_cmd(), 1'b0, '0);
        pace();
      end
    end

    settle();
    $display("run covered %0d commands (%0d directed) over %0d coefficient sets",
             n_accepted, NUM_DIRECTED, n_settings);
    $display("%0d result words compared, %0d mismatches", n_results, n_err);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/owvm_pkg.sv
rtl/owvm_front.sv
rtl/owvm_queue.sv
rtl/owvm_back.sv
rtl/omni_wheel_velocity_mixer.sv
rtl/owvm_checker.sv
sim/tb_omni_wheel_velocity_mixer.sv
